// ===== rtl/assert_macros.svh =====
// Assertion macros used by scd_engine of the selector channel DMA RTL.
// Define NO_ASSERTIONS to compile every check away; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) \
        else $error(msg);

// When the trigger holds, the property must hold at the same edge.
`define ASSERT_IMPLIES(label, clk_sig, rst_sig, trig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) \
        (trig) |-> (prop)) else $error(msg);

// When the trigger holds, the property must hold at the next edge.
`define ASSERT_NEXT(label, clk_sig, rst_sig, trig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) \
        (trig) |=> (prop)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk_sig, rst_sig, prop, msg)
`define ASSERT_IMPLIES(label, clk_sig, rst_sig, trig, prop, msg)
`define ASSERT_NEXT(label, clk_sig, rst_sig, trig, prop, msg)

`endif

`endif

// ===== rtl/scd_pkg.sv =====
// Types, codes and constants of the selector channel DMA.
// Used by every module of the block; depends on nothing.
package scd_pkg;

    localparam int ADDR_BITS = 24;
    localparam int ADDR_W = 24;

    localparam logic [ADDR_W-1:0] ADDR_MASK =
        ADDR_W'(((64'd1 << ADDR_BITS) - 64'd1) & 64'hFF_FFFF);

    localparam logic [7:0] ARMED_COUNT = 8'd4;
    localparam logic [7:0] PORT_READ_DATA = 8'hFF;

    // Bit positions in the mode byte.
    localparam int MODE_WRITE_BIT = 7;
    localparam int MODE_IO_BIT = 6;
    localparam int MODE_CNT_UP_BIT = 5;

    typedef enum logic [1:0] {
        OP_PORT_WR = 2'd0,
        OP_PORT_RD = 2'd1,
        OP_DMA     = 2'd2,
        OP_RSVD    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_DISARMED = 2'd1,
        STATUS_IO       = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [7:0]        mem_wdata;
        logic [ADDR_W-1:0] mem_addr;
        logic              mem_write;
        logic              mem_valid;
        logic [7:0]        port_rdata;
        logic [1:0]        status;
    } result_t;

endpackage

// ===== rtl/scd_in_stage.sv =====
// Input register of the selector channel DMA: holds one accepted transfer.
// Depends on scd_pkg.
module scd_in_stage
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  scd_pkg::item_t s_item,
    input  logic          advance,
    output logic          item_valid,
    output scd_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    scd_pkg::item_t item_reg;

    // The register can take a new transfer when empty or when its item moves on.
    assign s_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

// ===== rtl/scd_engine.sv =====
// Channel state and single-pass decode of one item into its result.
// Depends on scd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module scd_engine
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  scd_pkg::item_t   item,
    output scd_pkg::result_t result
);

    logic [23:0]                 shift_reg;
    logic [23:0]                 shift_next;
    logic [7:0]                  count_reg;
    logic [7:0]                  count_next;
    logic [scd_pkg::ADDR_W-1:0]  base_reg;
    logic [scd_pkg::ADDR_W-1:0]  base_next;
    logic [scd_pkg::ADDR_W-1:0]  index_reg;
    logic [scd_pkg::ADDR_W-1:0]  index_next;
    logic [scd_pkg::ADDR_W-1:0]  length;
    logic [7:0]                  mode;

    // Only the low three program bytes matter: the top byte leaves on the
    // next write, and the mode is always the newest byte.
    assign mode = shift_reg[7:0];
    assign length = index_reg + scd_pkg::ADDR_W'(1);

    always_comb
    begin
        shift_next = shift_reg;
        count_next = count_reg;
        base_next = base_reg;
        index_next = index_reg;
        result = '0;
        case (scd_pkg::op_t'(item.op))
            scd_pkg::OP_PORT_WR:
            begin
                shift_next = {shift_reg[15:0], item.data};
                base_next = shift_reg & scd_pkg::ADDR_MASK;
                count_next = count_reg + 8'd1;
                index_next = '0;
            end
            scd_pkg::OP_PORT_RD:
            begin
                count_next = '0;
                index_next = '0;
                result.port_rdata = scd_pkg::PORT_READ_DATA;
            end
            scd_pkg::OP_DMA:
            begin
                if (count_reg != scd_pkg::ARMED_COUNT)
                begin
                    result.status = scd_pkg::STATUS_DISARMED;
                    index_next = '0;
                end
                else if (mode[scd_pkg::MODE_IO_BIT])
                begin
                    result.status = scd_pkg::STATUS_IO;
                    index_next = '0;
                end
                else
                begin
                    result.mem_valid = 1'b1;
                    result.mem_addr = (base_reg + index_reg) & scd_pkg::ADDR_MASK;
                    if (mode[scd_pkg::MODE_WRITE_BIT])
                    begin
                        result.mem_write = 1'b1;
                        result.mem_wdata = item.data;
                    end
                    if (item.last)
                    begin
                        if (mode[scd_pkg::MODE_CNT_UP_BIT])
                        begin
                            base_next = (base_reg + length) & scd_pkg::ADDR_MASK;
                        end
                        else
                        begin
                            base_next = (base_reg - length) & scd_pkg::ADDR_MASK;
                        end
                        index_next = '0;
                    end
                    else
                    begin
                        index_next = length;
                    end
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            count_reg <= '0;
            base_reg <= '0;
            index_reg <= '0;
        end
        else if (fire)
        begin
            shift_reg <= shift_next;
            count_reg <= count_next;
            base_reg <= base_next;
            index_reg <= index_next;
        end
    end

    `ASSERT_NEXT(a_read_disarms, clk, rst_n,
        fire && item.op == scd_pkg::OP_PORT_RD, count_reg == 8'd0,
        "port read did not clear the write count")
    `ASSERT_IMPLIES(a_access_armed, clk, rst_n,
        fire && result.mem_valid,
        result.status == scd_pkg::STATUS_OK && count_reg == scd_pkg::ARMED_COUNT
            && !mode[scd_pkg::MODE_IO_BIT],
        "memory access issued on a channel that is not armed")
    `ASSERT_IMPLIES(a_idle_fields_zero, clk, rst_n,
        !result.mem_valid,
        result.mem_addr == '0 && !result.mem_write && result.mem_wdata == 8'd0,
        "memory fields set without an access")
    `ASSERT_NEXT(a_index_restarts, clk, rst_n,
        fire && (item.op == scd_pkg::OP_PORT_WR || item.op == scd_pkg::OP_PORT_RD
            || (item.op == scd_pkg::OP_DMA
                && (item.last || result.status != scd_pkg::STATUS_OK))),
        index_reg == '0,
        "byte index did not restart")

endmodule

// ===== rtl/scd_out_stage.sv =====
// Result register of the selector channel DMA toward the master side.
// Depends on scd_pkg.
module scd_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  scd_pkg::result_t result,
    output logic             advance,
    output logic             m_tvalid,
    input  logic             m_tready,
    output scd_pkg::result_t m_result
);

    logic             valid_reg;
    logic             valid_next;
    scd_pkg::result_t result_reg;

    // A new result may be loaded when the register is empty or being drained.
    assign advance = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && advance)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

endmodule

// ===== rtl/selector_channel_dma.sv =====
// Selector channel DMA: an item is registered in the input stage at the edge of its input
// transfer, decoded against the channel state, and its result registered in the output stage
// when that stage is empty or being drained.
// Throughput is one item per cycle while m_tready is high; with both registers full, a low m_tready
// stops input transfers in the same cycle.
// rst_n clears all channel state and the valid flags of both pipeline registers asynchronously.
module selector_channel_dma
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // op [1:0], data [9:2], zero [15:10]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status [1:0], port_rdata [9:2], mem_valid [10],
                                   // mem_write [11], mem_addr [35:12],
                                   // mem_wdata [43:36], zero [47:44]
);

    scd_pkg::item_t   s_item;
    scd_pkg::item_t   item;
    scd_pkg::result_t result;
    scd_pkg::result_t m_result;
    logic             item_valid;
    logic             advance;
    logic             fire;

    assign s_item.op = s_tdata[1:0];
    assign s_item.data = s_tdata[9:2];
    assign s_item.last = s_tlast;

    assign fire = item_valid && advance;

    scd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    scd_engine u_engine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    scd_out_stage u_out_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (item_valid),
        .result   (result),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {4'd0, m_result};

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for selector_channel_dma: a directed table, a write counter
// wrap and random programming and transfer sequences, checked against a predictor.
// Depends on rtl/scd_pkg.sv and rtl/selector_channel_dma.sv.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import scd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 110;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS = 40;

    // One row of the directed table. When typed is set, the expected result is
    // the given status and port read data with every memory field zero.
    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic       last;
        logic       typed;
        status_t    status;
        logic [7:0] port_rdata;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    // Predicted channel state.
    logic [31:0]       prog_shift = '0;
    logic [7:0]        wr_count = '0;
    logic [ADDR_W-1:0] chan_base = '0;
    logic [7:0]        chan_mode = '0;
    logic [ADDR_W-1:0] chan_index = '0;

    result_t  expected_results[$];
    dir_row_t dir_tbl[$];
    result_t  exp_res;
    result_t  got_res;
    result_t  typed_res;
    int       items_sent = 0;
    int       results_checked = 0;
    int       mismatches = 0;
    int       idle_phase = 0;
    int       cycle_cnt = 0;
    int       rand_start;
    int       pick;

    selector_channel_dma DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial
    begin
        wait (cycle_cnt == CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d results outstanding.",
                 cycle_cnt, expected_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Phases: 0 no idling, 1 sender idle, 2 receiver stalls, 3 both sides idle rarely.
    function automatic bit sender_idles();
        return (idle_phase == 1 && $urandom_range(99) < 59) ||
               (idle_phase == 3 && $urandom_range(99) < 6);
    endfunction

    function automatic bit receiver_stalls();
        return (idle_phase == 2 && $urandom_range(99) < 59) ||
               (idle_phase == 3 && $urandom_range(99) < 6);
    endfunction

    // Advances the predicted channel state by one item and returns its result.
    function automatic result_t predict_channel(op_t op, logic [7:0] data, logic last);
        result_t           r;
        logic [ADDR_W-1:0] len;
        r = '0;
        case (op)
            OP_PORT_WR:
            begin
                prog_shift = {prog_shift[23:0], data};
                chan_base = prog_shift[31:8] & ADDR_MASK;
                chan_mode = prog_shift[7:0];
                wr_count = wr_count + 8'd1;
                chan_index = '0;
            end
            OP_PORT_RD:
            begin
                wr_count = '0;
                chan_index = '0;
                r.port_rdata = PORT_READ_DATA;
            end
            OP_DMA:
            begin
                if (wr_count != ARMED_COUNT)
                begin
                    r.status = STATUS_DISARMED;
                    chan_index = '0;
                end
                else if (chan_mode[MODE_IO_BIT])
                begin
                    r.status = STATUS_IO;
                    chan_index = '0;
                end
                else
                begin
                    r.mem_valid = 1'b1;
                    r.mem_addr = (chan_base + chan_index) & ADDR_MASK;
                    if (chan_mode[MODE_WRITE_BIT])
                    begin
                        r.mem_write = 1'b1;
                        r.mem_wdata = data;
                    end
                    if (last)
                    begin
                        // The base moves by the transfer length, in the count direction.
                        len = chan_index + 1'b1;
                        if (chan_mode[MODE_CNT_UP_BIT])
                            chan_base = (chan_base + len) & ADDR_MASK;
                        else
                            chan_base = (chan_base - len) & ADDR_MASK;
                        chan_index = '0;
                    end
                    else
                    begin
                        chan_index = chan_index + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic void add_row(op_t op, logic [7:0] data, logic last, logic typed,
                                    status_t status, logic [7:0] port_rdata);
        dir_row_t row;
        row.op = op;
        row.data = data;
        row.last = last;
        row.typed = typed;
        row.status = status;
        row.port_rdata = port_rdata;
        dir_tbl.push_back(row);
    endfunction

    // Offers one item, waits for its transfer, then queues the expected result.
    task automatic send_item(op_t op, logic [7:0] data, logic last, bit typed,
                             result_t tres);
        result_t pred;
        idle_phase = (items_sent / PHASE_ITEMS) % 4;
        while (sender_idles())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata <= {6'd0, data, op};
        s_tlast <= last;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pred = predict_channel(op, data, last);
        expected_results.push_back(typed ? tres : pred);
        if (op != OP_RSVD)
            items_sent++;
    endtask

    // An optional port read, then three address bytes and a mode byte that mostly selects memory.
    task automatic program_channel(bit with_read);
        logic [7:0] mode;
        if (with_read)
            send_item(OP_PORT_RD, 8'($urandom_range(255)), 1'($urandom_range(1)), 0, '0);
        repeat (3)
            send_item(OP_PORT_WR, 8'($urandom_range(255)), 1'($urandom_range(1)), 0, '0);
        mode = 8'($urandom_range(255));
        if ($urandom_range(9) != 0)
            mode[MODE_IO_BIT] = 1'b0;
        send_item(OP_PORT_WR, mode, 1'($urandom_range(1)), 0, '0);
    endtask

    task automatic dma_burst(int len, bit closed);
        for (int i = 0; i < len; i++)
            send_item(OP_DMA, 8'($urandom_range(255)), closed && (i == len - 1), 0, '0);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer 0x%0h with no expected result", m_tdata);
                mismatches++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                got_res = result_t'(m_tdata[43:0]);
                check_field("status", 32'(exp_res.status), 32'(got_res.status));
                check_field("port_rdata", 32'(exp_res.port_rdata), 32'(got_res.port_rdata));
                check_field("mem_valid", 32'(exp_res.mem_valid), 32'(got_res.mem_valid));
                check_field("mem_write", 32'(exp_res.mem_write), 32'(got_res.mem_write));
                check_field("mem_addr", 32'(exp_res.mem_addr), 32'(got_res.mem_addr));
                check_field("mem_wdata", 32'(exp_res.mem_wdata), 32'(got_res.mem_wdata));
                check_field("pad", 32'd0, 32'(m_tdata[47:44]));
                results_checked++;
            end
        end
        m_tready <= !receiver_stalls();
    end

    initial
    begin
        // The channel is disarmed after reset, and the unused op answers all zero.
        add_row(OP_DMA,     8'h00, 1'b1, 1'b1, STATUS_DISARMED, 8'h00);
        add_row(OP_RSVD,    8'hFF, 1'b1, 1'b1, STATUS_OK,       8'h00);
        add_row(OP_PORT_RD, 8'h00, 1'b0, 1'b1, STATUS_OK,       PORT_READ_DATA);
        // Base 0x123456, memory write, count up.
        add_row(OP_PORT_WR, 8'h12, 1'b0, 1'b1, STATUS_OK,       8'h00);
        add_row(OP_PORT_WR, 8'h34, 1'b0, 1'b1, STATUS_OK,       8'h00);
        add_row(OP_PORT_WR, 8'h56, 1'b0, 1'b1, STATUS_OK,       8'h00);
        add_row(OP_PORT_WR, 8'hA0, 1'b1, 1'b1, STATUS_OK,       8'h00);
        add_row(OP_DMA,     8'hFF, 1'b0, 1'b0, STATUS_OK,       8'h00);
        add_row(OP_DMA,     8'h00, 1'b1, 1'b0, STATUS_OK,       8'h00);
        add_row(OP_DMA,     8'h5A, 1'b0, 1'b0, STATUS_OK,       8'h00);
        // A port read in the middle of a transfer disarms the channel.
        add_row(OP_PORT_RD, 8'hFF, 1'b1, 1'b1, STATUS_OK,       PORT_READ_DATA);
        // Base at the top of the address space, memory read, count down.
        add_row(OP_PORT_WR, 8'hFF, 1'b0, 1'b1, STATUS_OK,       8'h00);
        add_row(OP_PORT_WR, 8'hFF, 1'b0, 1'b1, STATUS_OK,       8'h00);
        add_row(OP_PORT_WR, 8'hFF, 1'b0, 1'b1, STATUS_OK,       8'h00);
        add_row(OP_PORT_WR, 8'h1F, 1'b0, 1'b1, STATUS_OK,       8'h00);
        add_row(OP_DMA,     8'hC3, 1'b1, 1'b0, STATUS_OK,       8'h00);
        add_row(OP_DMA,     8'h3C, 1'b0, 1'b0, STATUS_OK,       8'h00);
        add_row(OP_DMA,     8'h00, 1'b1, 1'b0, STATUS_OK,       8'h00);
        // I/O mode is refused, and a fifth write disarms the channel.
        add_row(OP_PORT_RD, 8'h00, 1'b0, 1'b1, STATUS_OK,       PORT_READ_DATA);
        add_row(OP_PORT_WR, 8'h00, 1'b0, 1'b1, STATUS_OK,       8'h00);
        add_row(OP_PORT_WR, 8'h00, 1'b0, 1'b1, STATUS_OK,       8'h00);
        add_row(OP_PORT_WR, 8'h00, 1'b0, 1'b1, STATUS_OK,       8'h00);
        add_row(OP_PORT_WR, 8'h40, 1'b0, 1'b1, STATUS_OK,       8'h00);
        add_row(OP_DMA,     8'h81, 1'b1, 1'b1, STATUS_IO,       8'h00);
        add_row(OP_PORT_WR, 8'h00, 1'b0, 1'b1, STATUS_OK,       8'h00);
        add_row(OP_DMA,     8'hFF, 1'b1, 1'b1, STATUS_DISARMED, 8'h00);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tbl[i])
        begin
            typed_res = '0;
            typed_res.status = dir_tbl[i].status;
            typed_res.port_rdata = dir_tbl[i].port_rdata;
            send_item(dir_tbl[i].op, dir_tbl[i].data, dir_tbl[i].last, dir_tbl[i].typed,
                      typed_res);
        end

        // 260 writes after a read bring the wrapped write counter back to four.
        send_item(OP_PORT_RD, 8'h00, 1'b0, 0, '0);
        repeat (256)
            send_item(OP_PORT_WR, 8'($urandom_range(255)), 1'($urandom_range(1)), 0, '0);
        program_channel(0);
        dma_burst(3, 1);

        rand_start = items_sent;
        while (items_sent - rand_start < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                // Without the leading read the counter runs past four.
                program_channel(pick < 68);
                repeat ($urandom_range(1, 3))
                    dma_burst($urandom_range(1, 12), $urandom_range(7) != 0);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_item(op_t'($urandom_range(3)), 8'($urandom_range(255)),
                              1'($urandom_range(1)), 0, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results from %0d items: directed table, write counter wrap,",
                 results_checked, items_sent);
        $display("random programming, transfer bursts and noise under four idling phases.");
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
